[rtl/tcc_pkg.sv]
`default_nettype none
package tcc_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        button_word;
    logic               recalibrate;
  } tcc_in_t;

  typedef struct packed {
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic        left_click;
    logic        right_press;
    logic        right_release;
  } tcc_out_t;

  localparam int NUM_CFG = 8;
  localparam logic [2:0] CFG_DEADBAND  = 3'd0;
  localparam logic [2:0] CFG_MOVE_THR  = 3'd1;
  localparam logic [2:0] CFG_FAR_X     = 3'd2;
  localparam logic [2:0] CFG_FAR_Y     = 3'd3;
  localparam logic [2:0] CFG_POS_X     = 3'd4;
  localparam logic [2:0] CFG_NEG_X     = 3'd5;
  localparam logic [2:0] CFG_POS_Y     = 3'd6;
  localparam logic [2:0] CFG_NEG_Y     = 3'd7;

  localparam logic [15:0] RECAL_WORD = 16'hFF80;
  localparam logic [16:0] CENTER     = 17'd32768;
  localparam int          TAB_FRAC   = 24;
  localparam int          TAB_LEN    = 24;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [39:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = 40'sd754974720;
      5'd1:  atan_tab = 40'sd445687602;
      5'd2:  atan_tab = 40'sd235489089;
      5'd3:  atan_tab = 40'sd119537938;
      5'd4:  atan_tab = 40'sd60000934;
      5'd5:  atan_tab = 40'sd30029717;
      5'd6:  atan_tab = 40'sd15018523;
      5'd7:  atan_tab = 40'sd7509720;
      5'd8:  atan_tab = 40'sd3754917;
      5'd9:  atan_tab = 40'sd1877466;
      5'd10: atan_tab = 40'sd938734;
      5'd11: atan_tab = 40'sd469367;
      5'd12: atan_tab = 40'sd234684;
      5'd13: atan_tab = 40'sd117342;
      5'd14: atan_tab = 40'sd58671;
      5'd15: atan_tab = 40'sd29335;
      5'd16: atan_tab = 40'sd14668;
      5'd17: atan_tab = 40'sd7334;
      5'd18: atan_tab = 40'sd3667;
      5'd19: atan_tab = 40'sd1833;
      5'd20: atan_tab = 40'sd917;
      5'd21: atan_tab = 40'sd458;
      5'd22: atan_tab = 40'sd229;
      5'd23: atan_tab = 40'sd115;
      default: atan_tab = 40'sd0;
    endcase
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_CRD_P_INIT, ST_CRD_P, ST_CRD_R_INIT, ST_CRD_R,
    ST_DEV, ST_SCALE, ST_MOVE, ST_OUT
  } tcc_state_t;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic crd_init_p;
    logic crd_init_r;
    logic crd_step;
    logic fin_p;
    logic fin_r;
    logic dev;
    logic scale;
    logic move;
  } tcc_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic crd_done;
  } tcc_sts_t;

endpackage
`default_nettype wire

[rtl/tcc_ctrl.sv]
`default_nettype none
module tcc_ctrl import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic out_taken,
  input  tcc_sts_t  sts,
  output tcc_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);
  tcc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_nxt = ST_CRD_P_INIT;
      end
      ST_CRD_P_INIT: begin
        cmd.crd_init_p = 1'b1;
        state_nxt = ST_CRD_P;
      end
      ST_CRD_P: begin
        if (sts.crd_done) begin
          cmd.fin_p = 1'b1;
          state_nxt = ST_CRD_R_INIT;
        end else begin
          cmd.crd_step = 1'b1;
        end
      end
      ST_CRD_R_INIT: begin
        cmd.crd_init_r = 1'b1;
        state_nxt = ST_CRD_R;
      end
      ST_CRD_R: begin
        if (sts.crd_done) begin
          cmd.fin_r = 1'b1;
          state_nxt = ST_DEV;
        end else begin
          cmd.crd_step = 1'b1;
        end
      end
      ST_DEV: begin
        cmd.dev = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/tcc_datapath.sv]
`default_nettype none
module tcc_datapath import tcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  tcc_cmd_t  cmd,
  input  tcc_in_t   in_item,
  input  wire logic [7:0] cfg_deadband,
  input  wire logic [7:0] cfg_move_thr,
  input  wire logic [7:0] cfg_far_x,
  input  wire logic [7:0] cfg_far_y,
  input  wire logic [7:0] cfg_pos_x,
  input  wire logic [7:0] cfg_neg_x,
  input  wire logic [7:0] cfg_pos_y,
  input  wire logic [7:0] cfg_neg_y,
  output tcc_sts_t  sts,
  output tcc_out_t  out_item
);
  localparam int SH    = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int AW    = 12 + ANGLE_FRAC_BITS;  // angle width, +/-360 deg range
  localparam int VW    = 44;                    // CORDIC vector width
  localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam logic [4:0] NUM_STEPS = 5'(NSTEP);

  tcc_in_t in_r;

  // Integer square root of (y*y + z*z) << 16, 49-bit radicand, 25-bit root.
  logic [49:0] rad_r;
  logic [25:0] rem_r;
  logic [24:0] root_r;
  logic [4:0]  sq_cnt_r;

  logic signed [31:0] yy, zz;
  assign yy = in_item.accel_y * in_item.accel_y;
  assign zz = in_item.accel_z * in_item.accel_z;

  logic [27:0] trial;
  logic [27:0] rem_sh;
  assign rem_sh = {rem_r, rad_r[49:48]};
  assign trial  = rem_sh - {1'b0, root_r, 2'b01};

  // CORDIC unit
  logic signed [VW-1:0] cx_r, cy_r;
  logic signed [39:0]   cz_r;
  logic [4:0]           ci_r;
  logic                 czero_r;
  logic signed [VW-1:0] dx, dy;
  assign dx = cx_r >>> ci_r;
  assign dy = cy_r >>> ci_r;

  logic signed [39:0]   zr;
  logic signed [AW-1:0] ang;
  assign zr  = cz_r + (40'sd1 <<< (SH - 1));
  assign ang = czero_r ? '0 : AW'(zr >>> SH);

  logic signed [AW-1:0] pitch_r, roll_r;
  logic signed [9:0]    roll_off_r, pitch_off_r;
  logic                 calib_r;
  logic [16:0]          pos_x_r, pos_y_r;
  logic                 toggle_r;
  logic                 lc_r, rp_r, rr_r;

  function automatic logic signed [9:0] trunc_int(input logic signed [AW-1:0] v);
    logic [AW-1:0] m;
    m = v[AW-1] ? AW'(-v) : v;
    m = m >> ANGLE_FRAC_BITS;
    trunc_int = v[AW-1] ? 10'(-m) : 10'(m);
  endfunction

  function automatic logic signed [AW+8:0] fixed_dev(
    input logic signed [AW-1:0] a, input logic signed [9:0] off, input logic [7:0] far,
    input logic [7:0] db);
    logic signed [AW:0] d;
    logic [AW:0] mag;
    logic [AW:0] lim;
    d   = (AW+1)'(a) - ((AW+1)'(off) <<< ANGLE_FRAC_BITS);
    mag = d[AW] ? (AW+1)'(-d) : d;
    lim = (AW+1)'(db) << ANGLE_FRAC_BITS;
    if (mag > lim) fixed_dev = (AW+9)'(d) * $signed({1'b0, far});
    else fixed_dev = (AW+9)'(d);
  endfunction

  logic signed [AW+8:0] dvx_r, dvy_r;
  logic signed [AW+8:0] stx_r, sty_r;
  logic move_ok_r;

  function automatic logic signed [AW+8:0] trunc_step(input logic signed [AW+8:0] v);
    logic [AW+8:0] m;
    m = v[AW+8] ? (AW+9)'(-v) : v;
    m = m >> ANGLE_FRAC_BITS;
    trunc_step = v[AW+8] ? (AW+9)'(-m) : (AW+9)'(m);
  endfunction

  function automatic logic [16:0] move_pos(input logic [16:0] p,
    input logic signed [AW+8:0] d, input logic [7:0] pg, input logic [7:0] ng);
    logic signed [AW+20:0] prod, np;
    prod = (AW+21)'(d) * $signed({1'b0, d[AW+8] ? ng : pg});
    np   = (AW+21)'($signed({1'b0, p})) - prod;
    if (np < 0) move_pos = 17'd0;
    else if (np > 65535) move_pos = 17'd65535;
    else move_pos = 17'(np);
  endfunction

  logic signed [AW+8:0] tx, ty;
  logic [AW+8:0] ax_m, ay_m;
  assign tx   = trunc_step(dvx_r);
  assign ty   = trunc_step(dvy_r);
  assign ax_m = tx[AW+8] ? (AW+9)'(-tx) : tx;
  assign ay_m = ty[AW+8] ? (AW+9)'(-ty) : ty;

  logic recal_word;
  assign recal_word = (in_r.button_word == RECAL_WORD);

  assign sts.sqrt_done = (sq_cnt_r == 5'd24);
  assign sts.crd_done  = (ci_r == NUM_STEPS) || czero_r;

  logic left_dn, right_dn, tg1;
  assign left_dn  = !in_r.button_word[8];
  assign right_dn = !in_r.button_word[9];
  assign tg1      = left_dn ? !toggle_r : toggle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_off_r  <= '0;
      pitch_off_r <= '0;
      calib_r     <= 1'b0;
      pos_x_r     <= CENTER;
      pos_y_r     <= CENTER;
      toggle_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        in_r     <= in_item;
        rad_r    <= {1'b0, 33'(yy) + 33'(zz), 16'd0};
        rem_r    <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
      end
      if (cmd.sqrt_step) begin
        rad_r    <= rad_r << 2;
        sq_cnt_r <= sq_cnt_r + 5'd1;
        if (!trial[27]) begin
          rem_r  <= 26'(trial);
          root_r <= {root_r[23:0], 1'b1};
        end else begin
          rem_r  <= 26'(rem_sh);
          root_r <= {root_r[23:0], 1'b0};
        end
      end
      if (cmd.crd_init_p || cmd.crd_init_r) begin
        logic signed [VW-1:0] x0, y0;
        x0 = cmd.crd_init_p ? -(VW'(in_r.accel_x) <<< 8) : (VW'(in_r.accel_y) <<< 8);
        y0 = cmd.crd_init_p ? $signed(VW'(root_r)) : (VW'(in_r.accel_z) <<< 8);
        ci_r    <= '0;
        czero_r <= (x0 == 0) && (y0 == 0);
        if (x0 < 0) begin
          cx_r <= -x0;
          cy_r <= -y0;
          cz_r <= (y0 >= 0) ? 40'sd3019898880 : -40'sd3019898880;
        end else begin
          cx_r <= x0;
          cy_r <= y0;
          cz_r <= '0;
        end
      end
      if (cmd.crd_step && !czero_r) begin
        ci_r <= ci_r + 5'd1;
        if (cy_r > 0) begin
          cx_r <= cx_r + dy;
          cy_r <= cy_r - dx;
          cz_r <= cz_r + atan_tab(ci_r);
        end else begin
          cx_r <= cx_r - dy;
          cy_r <= cy_r + dx;
          cz_r <= cz_r - atan_tab(ci_r);
        end
      end
      if (cmd.fin_p) pitch_r <= ang - AW'(90 <<< ANGLE_FRAC_BITS);
      if (cmd.fin_r) begin
        roll_r <= ang + AW'(90 <<< ANGLE_FRAC_BITS);
        if (!calib_r || in_r.recalibrate) begin
          pitch_off_r <= trunc_int(pitch_r);
          roll_off_r  <= trunc_int(ang + AW'(90 <<< ANGLE_FRAC_BITS));
          calib_r     <= 1'b1;
          if (in_r.recalibrate) begin
            pos_x_r <= CENTER;
            pos_y_r <= CENTER;
          end
        end
      end
      if (cmd.dev) begin
        dvx_r <= fixed_dev(roll_r, roll_off_r, cfg_far_x, cfg_deadband);
        dvy_r <= fixed_dev(pitch_r, pitch_off_r, cfg_far_y, cfg_deadband);
        if (recal_word) begin
          pos_x_r     <= CENTER;
          pos_y_r     <= CENTER;
          roll_off_r  <= trunc_int(roll_r);
          pitch_off_r <= trunc_int(pitch_r);
        end
      end
      if (cmd.scale) begin
        stx_r     <= tx;
        sty_r     <= ty;
        move_ok_r <= (ax_m > (AW+9)'(cfg_move_thr)) && (ay_m > (AW+9)'(cfg_move_thr));
      end
      if (cmd.move) begin
        if (move_ok_r) begin
          pos_x_r <= move_pos(pos_x_r, stx_r, cfg_pos_x, cfg_neg_x);
          pos_y_r <= move_pos(pos_y_r, sty_r, cfg_pos_y, cfg_neg_y);
        end
        lc_r <= left_dn && !toggle_r;
        rp_r <= right_dn && !tg1;
        rr_r <= right_dn && tg1;
        toggle_r <= right_dn ? !tg1 : tg1;
      end
    end
  end

  assign out_item.cursor_x      = pos_x_r[15:0];
  assign out_item.cursor_y      = pos_y_r[15:0];
  assign out_item.left_click    = lc_r;
  assign out_item.right_press   = rp_r;
  assign out_item.right_release = rr_r;
endmodule
`default_nettype wire

[rtl/tilt_cursor_controller.sv]
`default_nettype none
// Tilt cursor controller: turns accelerometer samples into an absolute cursor.
// The in_ channel carries one sample and button word per transaction; the
// out_ channel returns one cursor position with click events per transaction.
// The cfg_ channel writes the eight 8-bit gain and threshold registers and is
// always ready; the user must write them only while no transaction is in
// flight, which the block itself does not enforce. Each input passes through
// the bit-serial square root, then through the single shared CORDIC unit once
// per angle (setup, rotations, rounding), then through deviation, scaling,
// cursor update and the output register.
// A zero vector skips the rotations of that angle.
// One transaction is in the core at a time, so no new input is taken until the
// core has handed its result to the output register.
// A result waits in the output register until out_ready. The core takes the
// next input meanwhile and holds its own result until the register frees up;
// from then on in_ready stays low until the stall ends.
// Synchronous reset centers the cursor, clears the offsets, the click toggle and
// the calibration flag, and restores the register defaults. The first sample
// after reset calibrates the offsets.
module tilt_cursor_controller import tcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  tcc_in_t         in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tcc_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  logic [7:0] cfg_r [NUM_CFG];
  tcc_cmd_t cmd;
  tcc_sts_t sts;
  logic busy;
  logic res_valid, res_taken;
  tcc_out_t res_item;
  logic out_valid_r;
  tcc_out_t out_data_r;

  assign cfg_ready = 1'b1;

  // Register file with the documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[CFG_DEADBAND] <= 8'd40;
      cfg_r[CFG_MOVE_THR] <= 8'd3;
      cfg_r[CFG_FAR_X]    <= 8'd4;
      cfg_r[CFG_FAR_Y]    <= 8'd4;
      cfg_r[CFG_POS_X]    <= 8'd20;
      cfg_r[CFG_NEG_X]    <= 8'd40;
      cfg_r[CFG_POS_Y]    <= 8'd20;
      cfg_r[CFG_NEG_Y]    <= 8'd40;
    end else if (cfg_valid) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  assign in_ready = !busy;

  // The output register takes a finished result whenever it is empty or is
  // being emptied in the same cycle.
  assign res_taken = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_taken) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_item;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid),
    .out_taken (res_taken),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (res_valid)
  );

  tcc_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_item      (in_data),
    .cfg_deadband (cfg_r[CFG_DEADBAND]),
    .cfg_move_thr (cfg_r[CFG_MOVE_THR]),
    .cfg_far_x    (cfg_r[CFG_FAR_X]),
    .cfg_far_y    (cfg_r[CFG_FAR_Y]),
    .cfg_pos_x    (cfg_r[CFG_POS_X]),
    .cfg_neg_x    (cfg_r[CFG_NEG_X]),
    .cfg_pos_y    (cfg_r[CFG_POS_Y]),
    .cfg_neg_y    (cfg_r[CFG_NEG_Y]),
    .sts          (sts),
    .out_item     (res_item)
  );

  // The core keeps its result while the output register is held by a stall.
  a_core_waits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid && !out_ready |=> res_valid)
    else $error("core result lost");

  // A pending result stays until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

  // Right press and release never fire together.
  a_right_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.right_press && out_data.right_release))
    else $error("right press and release together");
endmodule
`default_nettype wire
